// ===== src/bilinear_table_interpolator_assert.svh =====
// Assertion macros for the bilinear table interpolator.
// No dependencies; included by the top level only.
`ifndef BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BTI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bti assertion failed");

// Next-cycle implication, disabled during reset
`define BTI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bti assertion failed");

`endif

// ===== src/bti_pkg.sv =====
// Shared types and constants of the bilinear table interpolator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package bti_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int AW = $clog2(TABLE_DEPTH);      // table address width
  localparam int CW = AW + 1;                   // entry count width
  localparam int RL_W = 11;                     // row length register width
  localparam int SW = ((CW > RL_W) ? CW : RL_W) + 2; // index sum width
  localparam int DW = 32;                       // Q16.16 word
  localparam int DCW = $clog2(DW + 1);          // divider step counter

  localparam logic [DW-1:0] Y_ONE = 32'h0001_0000;
  localparam logic [DW-1:0] HIGH_Y_RESET = 32'd21845;
  localparam logic [RL_W-1:0] ROW_LEN_RESET = 11'd1;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_X_RANGE = 2'd1;
  localparam logic [1:0] ST_Y_BRACKET = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // register indexes
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_HIGH_Y = 1'b1;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_RD_LAST, OP_SET_HIGH, OP_RD_X, OP_X_HIT, OP_X_NEXT,
    OP_ERR_X, OP_RD_Y, OP_Y_HIT, OP_Y_NEXT, OP_ERR_Y, OP_RD_Z0, OP_RD_Z1,
    OP_DIVX_START, OP_DIV_STEP, OP_DIVY_START, OP_LERP0, OP_MUL, OP_LERP1,
    OP_LERP2, OP_SET_RES, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic y_high;
    logic x_end;
    logic x_hit;
    logic y_end;
    logic y_hit;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LAST_RD, S_LAST_CHK, S_X_RD, S_X_CHK, S_Y_RD, S_Y_CHK, S_Z_RD0,
    S_Z_RD1, S_Z_CAP, S_DIV_X, S_DIV_Y, S_MUL0, S_LD1, S_MUL1, S_LD2, S_MUL2,
    S_FIN, S_EMIT
  } ctrl_state_t;
endpackage
`default_nettype wire

// ===== src/bti_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// ===== src/bti_datapath.sv =====
// Datapath: table RAMs, bracket search indexes, divider, lerp unit, output register.
// Depends on bti_pkg and bti_ram.
`default_nettype none
module bti_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bti_pkg::dp_cmd_t         cmd,
  output bti_pkg::dp_status_t           st,
  input  wire logic [95:0]              in_data,
  input  wire logic                     in_type,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [31:0]              cfg_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [39:0]                   out_data
);
  import bti_pkg::*;

  logic [RL_W-1:0] row_len;
  logic [DW-1:0]   high_y;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   idx_i, idx_j;
  logic [DW-1:0]   xq, yq, x0, x1;
  logic [DW-1:0]   z00, z0r, z10, z1r, z0, tx, ty;
  logic [DW:0]     rem;
  logic [DW-1:0]   den, quot;
  logic [DCW-1:0]  dcnt;
  logic [DW-1:0]   la, lb, lt;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   pend_z, res_z;
  logic [1:0]      pend_st, res_st;

  logic [DW-1:0] in_x, in_y, in_z, y_clamp;
  logic [DW-1:0] xa, xb, ya, yb, za, zb;
  logic [SW-1:0] sum_ir, sum_j1, sum_jr, sum_j1r;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] ya_addr, za_addr, zb_addr;
  logic          we;
  logic [DW:0]   div_sh;
  logic          up;
  logic [DW-1:0] mag, lq, lres;
  logic [2*DW-1:0] rnd;

  assign in_x = in_data[31:0];
  assign in_y = in_data[63:32];
  assign in_z = in_data[95:64];
  assign y_clamp = ($signed(in_y) < $signed(Y_ONE)) ? Y_ONE : in_y;

  // index sums for bracket ends and addresses
  assign sum_ir  = SW'(idx_i) + SW'(row_len);
  assign sum_j1  = SW'(idx_j) + SW'(1);
  assign sum_jr  = SW'(idx_j) + SW'(row_len);
  assign sum_j1r = sum_j1 + SW'(row_len);
  assign cnt_m1  = cnt - CW'(1);

  assign we = (cmd.op == OP_ACCEPT) && (in_type == REQ_LOAD) && !st.full;
  assign ya_addr = (cmd.op == OP_RD_LAST) ? cnt_m1[AW-1:0] : idx_j[AW-1:0];
  assign za_addr = (cmd.op == OP_RD_Z1) ? sum_j1[AW-1:0] : idx_j[AW-1:0];
  assign zb_addr = (cmd.op == OP_RD_Z1) ? sum_j1r[AW-1:0] : sum_jr[AW-1:0];

  bti_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk(clk), .we(we), .waddr(cnt[AW-1:0]), .wdata(in_x),
    .raddr_a(idx_i[AW-1:0]), .raddr_b(sum_ir[AW-1:0]), .rdata_a(xa), .rdata_b(xb)
  );
  bti_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk(clk), .we(we), .waddr(cnt[AW-1:0]), .wdata(in_y),
    .raddr_a(ya_addr), .raddr_b(sum_j1[AW-1:0]), .rdata_a(ya), .rdata_b(yb)
  );
  bti_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_z_ram (
    .clk(clk), .we(we), .waddr(cnt[AW-1:0]), .wdata(in_z),
    .raddr_a(za_addr), .raddr_b(zb_addr), .rdata_a(za), .rdata_b(zb)
  );

  // status towards the controller
  always_comb begin
    st.full     = (cnt == CW'(TABLE_DEPTH));
    st.empty    = (cnt == '0);
    st.y_high   = $signed(yq) > $signed(ya);
    st.x_end    = sum_ir >= SW'(cnt);
    st.x_hit    = ($signed(xq) >= $signed(xa)) && ($signed(xq) < $signed(xb));
    st.y_end    = sum_j1r >= SW'(cnt);
    st.y_hit    = ($signed(yq) >= $signed(ya)) && ($signed(yq) < $signed(yb));
    st.div_done = (dcnt == '0);
    st.out_free = !out_valid || out_ready;
  end

  // restoring divider step and lerp finish
  assign div_sh = {rem[DW-1:0], 1'b0};
  assign up   = $signed(lb) >= $signed(la);
  assign mag  = up ? (lb - la) : (la - lb);
  assign rnd  = prod + {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}};
  assign lq   = rnd[2*DW-1:DW];
  assign lres = up ? (la + lq) : (la - lq);

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_len   <= ROW_LEN_RESET;
      high_y    <= HIGH_Y_RESET;
      cnt       <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_LENGTH: row_len <= cfg_data[RL_W-1:0];
          REG_HIGH_Y:     high_y <= cfg_data;
          default: ;
        endcase
      end
      if (we) begin
        cnt <= cnt + CW'(1);
      end
      case (cmd.op)
        OP_DIVX_START, OP_DIVY_START: dcnt <= DCW'(DW);
        OP_DIV_STEP: dcnt <= dcnt - DCW'(1);
        default: ;
      endcase
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        pend_z <= '0;
        if (in_type == REQ_LOAD) begin
          pend_st <= st.full ? ST_FULL : ST_OK;
        end else begin
          xq      <= in_x;
          yq      <= y_clamp;
          idx_i   <= '0;
          pend_st <= st.empty ? ST_X_RANGE : ST_OK;
        end
      end
      OP_SET_HIGH: pend_z <= high_y;
      OP_X_HIT: begin
        x0    <= xa;
        x1    <= xb;
        idx_j <= idx_i;
      end
      OP_X_NEXT: idx_i <= idx_i + CW'(1);
      OP_ERR_X: pend_st <= ST_X_RANGE;
      OP_Y_HIT: begin
        rem <= {1'b0, yq - ya};
        den <= yb - ya;
      end
      OP_Y_NEXT: idx_j <= idx_j + CW'(1);
      OP_ERR_Y: pend_st <= ST_Y_BRACKET;
      OP_RD_Z1: begin
        z00 <= za;
        z0r <= zb;
      end
      OP_DIVX_START: begin
        z10 <= za;
        z1r <= zb;
        ty  <= den;            // y denominator parked while x divides
        tx  <= rem[DW-1:0];    // y numerator parked
        rem <= {1'b0, xq - x0};
        den <= x1 - x0;
      end
      OP_DIV_STEP: begin
        if (div_sh >= {1'b0, den}) begin
          rem  <= div_sh - {1'b0, den};
          quot <= {quot[DW-2:0], 1'b1};
        end else begin
          rem  <= div_sh;
          quot <= {quot[DW-2:0], 1'b0};
        end
      end
      OP_DIVY_START: begin
        rem <= {1'b0, tx};
        den <= ty;
        tx  <= quot;
      end
      OP_LERP0: begin
        ty <= quot;
        la <= z00;
        lb <= z0r;
        lt <= tx;
      end
      OP_MUL: prod <= mag * lt;
      OP_LERP1: begin
        z0 <= lres;
        la <= z10;
        lb <= z1r;
        lt <= tx;
      end
      OP_LERP2: begin
        la <= z0;
        lb <= lres;
        lt <= ty;
      end
      OP_SET_RES: pend_z <= lres;
      OP_EMIT: begin
        res_z  <= pend_z;
        res_st <= pend_st;
      end
      default: ;
    endcase
  end

  assign out_data = {6'd0, res_st, res_z};
endmodule
`default_nettype wire

// ===== src/bti_ctrl.sv =====
// Controller state machine: sequences load, bracket search, divide and lerp steps.
// Depends on bti_pkg.
`default_nettype none
module bti_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_type,
  output logic                     in_ready,
  input  wire bti_pkg::dp_status_t st,
  output bti_pkg::dp_cmd_t         cmd
);
  import bti_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        state_next = (in_type == REQ_LOAD || st.empty) ? S_EMIT : S_LAST_RD;
      end
      S_LAST_RD:  state_next = S_LAST_CHK;
      S_LAST_CHK: state_next = st.y_high ? S_EMIT : S_X_RD;
      S_X_RD:     state_next = st.x_end ? S_EMIT : S_X_CHK;
      S_X_CHK:    state_next = st.x_hit ? S_Y_RD : S_X_RD;
      S_Y_RD:     state_next = st.y_end ? S_EMIT : S_Y_CHK;
      S_Y_CHK:    state_next = st.y_hit ? S_Z_RD0 : S_Y_RD;
      S_Z_RD0:    state_next = S_Z_RD1;
      S_Z_RD1:    state_next = S_Z_CAP;
      S_Z_CAP:    state_next = S_DIV_X;
      S_DIV_X:    if (st.div_done) state_next = S_DIV_Y;
      S_DIV_Y:    if (st.div_done) state_next = S_MUL0;
      S_MUL0:     state_next = S_LD1;
      S_LD1:      state_next = S_MUL1;
      S_MUL1:     state_next = S_LD2;
      S_LD2:      state_next = S_MUL2;
      S_MUL2:     state_next = S_FIN;
      S_FIN:      state_next = S_EMIT;
      S_EMIT:     if (st.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE:     if (in_valid) cmd.op = OP_ACCEPT;
      S_LAST_RD:  cmd.op = OP_RD_LAST;
      S_LAST_CHK: if (st.y_high) cmd.op = OP_SET_HIGH;
      S_X_RD:     cmd.op = st.x_end ? OP_ERR_X : OP_RD_X;
      S_X_CHK:    cmd.op = st.x_hit ? OP_X_HIT : OP_X_NEXT;
      S_Y_RD:     cmd.op = st.y_end ? OP_ERR_Y : OP_RD_Y;
      S_Y_CHK:    cmd.op = st.y_hit ? OP_Y_HIT : OP_Y_NEXT;
      S_Z_RD0:    cmd.op = OP_RD_Z0;
      S_Z_RD1:    cmd.op = OP_RD_Z1;
      S_Z_CAP:    cmd.op = OP_DIVX_START;
      S_DIV_X:    cmd.op = st.div_done ? OP_DIVY_START : OP_DIV_STEP;
      S_DIV_Y:    cmd.op = st.div_done ? OP_LERP0 : OP_DIV_STEP;
      S_MUL0, S_MUL1, S_MUL2: cmd.op = OP_MUL;
      S_LD1:      cmd.op = OP_LERP1;
      S_LD2:      cmd.op = OP_LERP2;
      S_FIN:      cmd.op = OP_SET_RES;
      S_EMIT:     if (st.out_free) cmd.op = OP_EMIT;
      default:    cmd.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/bilinear_table_interpolator.sv =====
// Top level of the bilinear table interpolator: controller plus datapath.
// Depends on bti_pkg, bti_ctrl, bti_datapath and the assertion header.
//
//  channel  | direction | contents
//  s_axis   | in        | tuser: req_type; tdata: x_value, y_value, z_value
//  m_axis   | out       | tdata: z_result, status
//  cfg      | in        | 0 row_length, 1 high_y_value
//
// A load goes straight to its result; a query normally searches for brackets at
// i and j (each search step reads the RAM ports and then checks the bracket),
// then runs two divides and three lerps before its result is emitted.
// Reset is synchronous; the table is not cleared, entry count starts at zero.
// One item is held at a time; a finished result waits in the output register.
`default_nettype none
module bilinear_table_interpolator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // x_value, y_value, z_value
  input  wire logic [0:0]  s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // z_result, status, zero pad
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import bti_pkg::*;
  `include "bilinear_table_interpolator_assert.svh"

  dp_cmd_t    cmd;
  dp_status_t st;

  bti_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_type(s_axis_tuser[0]),
    .in_ready(s_axis_tready), .st(st), .cmd(cmd)
  );

  bti_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .in_data(s_axis_tdata),
    .in_type(s_axis_tuser[0]), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata)
  );

  // checks
  `BTI_ASSERT_NXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BTI_ASSERT_IMP(a_err_zero, clk, rst, m_axis_tvalid && (m_axis_tdata[33:32] != ST_OK), m_axis_tdata[31:0] == 32'd0)
  `BTI_ASSERT_IMP(a_emit_free, clk, rst, cmd.op == OP_EMIT, !m_axis_tvalid || m_axis_tready)
endmodule
`default_nettype wire
